### hdl/gamma_contrast_brightness_ramp_top_defines.svh
// Assertion macros shared by the ramp block.
// Expects clk and rst_n in the scope of each use.
`ifndef GAMMA_CONTRAST_BRIGHTNESS_RAMP_TOP_DEFINES_SVH
`define GAMMA_CONTRAST_BRIGHTNESS_RAMP_TOP_DEFINES_SVH

`define GCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`define GCB_ASSERT_NEVER(label, expr, msg) `GCB_ASSERT(label, !(expr), msg)

`endif

### hdl/gcb_pkg.sv
// Package for the ramp block: widths, register codes, config struct and the
// elaboration-time functions for the log2 constant and the root table.
`timescale 1ns / 1ps

package gcb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int LOG_FRAC  = 24;
    localparam int ONE_Q     = 1 << FRAC_BITS;
    localparam int LOW_BOUND  = (ONE_Q + 9) / 10;
    localparam int BRIGHT_MAX = (4 * ONE_Q) / 5;

    localparam int LEVEL_W  = 8;
    localparam int RAMP_W   = 16;
    localparam int CFG_W    = 16;
    localparam int BRIGHT_W = 14;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_GAMMA    = 2'd0;
    localparam logic [IDX_W-1:0] REG_CONTRAST = 2'd1;
    localparam logic [IDX_W-1:0] REG_BRIGHT   = 2'd2;

    localparam int LINE_W   = 26;
    localparam int TOP_W    = 5;
    localparam int NORM_W   = 24;
    localparam int M_W      = 31;
    localparam int LOG_W    = TOP_W + LOG_FRAC;
    localparam int DIV_BITS = 30;
    localparam int N_W      = LOG_W + FRAC_BITS;
    localparam int N_HI_W   = N_W - DIV_BITS;
    localparam int U_W      = 30;
    localparam int SH_W     = 6;
    localparam int CURVE_W  = 31;

    localparam int BUF_DEPTH_DEF = 128;

    typedef struct packed {
        logic [CFG_W-1:0]           gamma;
        logic [CFG_W-1:0]           contrast;
        logic signed [BRIGHT_W-1:0] brightness;
    } cfg_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        v     = v_in;
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= res + bit_v)
            begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // 2^(2^-(k+1)) with 30 fraction bits
    function automatic logic [M_W-1:0] root_val(input int k);
        logic [63:0] r;
        r = isqrt64(64'd1 << 61);
        for (int j = 1; j <= k; j++)
        begin
            r = isqrt64(r << 30);
        end
        return r[M_W-1:0];
    endfunction

    function automatic logic [LOG_W-1:0] log2_fix(input logic [63:0] x);
        int          top;
        logic [63:0] m;
        logic [LOG_FRAC-1:0] fr;
        top = 0;
        fr  = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
                top = i;
        end
        m = x << (30 - top);
        for (int k = 0; k < LOG_FRAC; k++)
        begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd2 << 30))
            begin
                m     = m >> 1;
                fr[0] = 1'b1;
            end
        end
        return {TOP_W'(top), fr};
    endfunction

    localparam logic [LOG_W-1:0] LOG2_FULL = log2_fix(64'd255 << FRAC_BITS);

endpackage

### hdl/gcb_core.sv
// Ramp datapath: contrast line, pipelined log2, restoring divide by gamma,
// pipelined exp2 and brightness/saturation. Needs gcb_pkg.
`timescale 1ns / 1ps

module gcb_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gcb_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    input  logic [gcb_pkg::LEVEL_W-1:0] level,
    output logic                        out_valid,
    output logic [gcb_pkg::RAMP_W-1:0]  ramp_value
);
    import gcb_pkg::*;

    localparam int ST_B    = 1;
    localparam int ST_C    = 2;
    localparam int ST_LOG0 = 3;
    localparam int ST_D    = ST_LOG0 + LOG_FRAC;
    localparam int ST_E    = ST_D + 1;
    localparam int ST_DIV0 = ST_E + 1;
    localparam int ST_F    = ST_DIV0 + DIV_BITS;
    localparam int ST_EXP0 = ST_F + 1;
    localparam int ST_G    = ST_EXP0 + LOG_FRAC;
    localparam int ST_H    = ST_G + 1;
    localparam int N_STG   = ST_H + 1;

    localparam logic [U_W-1:0]  E_MAX     = U_W'(2) << LOG_FRAC;
    localparam logic [U_W-1:0]  E_MIN_MAG = U_W'(30) << LOG_FRAC;
    localparam logic [U_W-1:0]  U_OFF     = U_W'(32) << LOG_FRAC;
    localparam logic [SH_W-1:0] SH_BASE   = SH_W'(14 + 32);
    localparam int              BRIGHT_SH = 7 + 16 - FRAC_BITS;
    localparam int              BIG_W     = M_W + 8;

    logic [N_STG-1:0]          vld_reg;
    logic signed [LINE_W-1:0]  line_reg [0:ST_G-1];
    logic                      pos_reg  [ST_B:ST_F-1];
    logic [TOP_W-1:0]          top_reg  [ST_B:ST_D-1];
    logic [M_W-1:0]            m_reg    [ST_C:ST_D-2];
    logic [LOG_FRAC-1:0]       lfr_reg  [ST_LOG0:ST_D-1];
    logic                      neg_reg  [ST_D:ST_F-1];
    logic [N_W-1:0]            n_d_reg;
    logic                      ovf_reg  [ST_E:ST_F-1];
    logic [CFG_W-1:0]          rem_reg  [ST_E:ST_F-2];
    logic [DIV_BITS-1:0]       nlo_reg  [ST_E:ST_F-2];
    logic [DIV_BITS-1:0]       q_reg    [ST_DIV0:ST_F-1];
    logic                      zero_reg [ST_F:ST_G-1];
    logic [SH_W-1:0]           sh_reg   [ST_F:ST_G-1];
    logic [LOG_FRAC-1:0]       efr_reg  [ST_F:ST_G-2];
    logic [M_W-1:0]            acc_reg  [ST_EXP0:ST_G-1];
    logic signed [CURVE_W-1:0] curve_reg;
    logic [RAMP_W-1:0]         ramp_reg;

    logic [CFG_W-1:0]           g_cl;
    logic signed [CFG_W:0]      c_cl;
    logic signed [BRIGHT_W-1:0] b_cl;

    always_comb
    begin
        g_cl = (cfg.gamma <= CFG_W'(LOW_BOUND)) ? CFG_W'(LOW_BOUND) : cfg.gamma;
        c_cl = (cfg.contrast < CFG_W'(LOW_BOUND)) ? (CFG_W+1)'(LOW_BOUND)
                                                   : $signed({1'b0, cfg.contrast});
        if (cfg.brightness > $signed(BRIGHT_W'(BRIGHT_MAX)))
            b_cl = $signed(BRIGHT_W'(BRIGHT_MAX));
        else if (cfg.brightness < -$signed(BRIGHT_W'(BRIGHT_MAX)))
            b_cl = -$signed(BRIGHT_W'(BRIGHT_MAX));
        else
            b_cl = cfg.brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[N_STG-2:0], in_valid};
    end

    // stage A: contrast line
    logic signed [8:0]        lev_off;
    logic signed [LINE_W-1:0] line_next;

    always_comb
    begin
        lev_off   = $signed({1'b0, level}) - 9'sd127;
        line_next = LINE_W'(lev_off * c_cl) + LINE_W'(127 * ONE_Q);
    end

    // stage B: top set bit
    logic [TOP_W-1:0] top_next;

    always_comb
    begin
        top_next = '0;
        for (int i = 0; i < NORM_W; i++)
        begin
            if (line_reg[0][i])
                top_next = TOP_W'(i);
        end
    end

    // stages A, B, C and the plain carries
    always_ff @(posedge clk)
    begin
        line_reg[0] <= line_next;
        for (int i = 1; i < ST_G; i++)
            line_reg[i] <= line_reg[i-1];
        pos_reg[ST_B] <= (line_reg[0] > 0);
        for (int i = ST_B + 1; i < ST_F; i++)
            pos_reg[i] <= pos_reg[i-1];
        top_reg[ST_B] <= top_next;
        for (int i = ST_B + 1; i < ST_D; i++)
            top_reg[i] <= top_reg[i-1];
        m_reg[ST_C] <= M_W'(line_reg[ST_B][NORM_W-1:0]) << (TOP_W'(M_W - 1) - top_reg[ST_B]);
    end

    // log2 fraction: one squaring per stage
    for (genvar k = 0; k < LOG_FRAC; k++)
    begin : g_log
        localparam int S = ST_LOG0 + k;
        logic [2*M_W-1:0] sq;
        logic [M_W:0]     sqs;

        always_comb
        begin
            sq  = m_reg[S-1] * m_reg[S-1];
            sqs = sq[2*M_W-1:M_W-1];
        end

        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
                lfr_reg[S] <= {{(LOG_FRAC-1){1'b0}}, sqs[M_W]};
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
                lfr_reg[S] <= {lfr_reg[S-1][LOG_FRAC-2:0], sqs[M_W]};
        end

        if (k < LOG_FRAC - 1)
        begin : g_m
            always_ff @(posedge clk)
                m_reg[S] <= sqs[M_W] ? sqs[M_W:1] : sqs[M_W-1:0];
        end
    end

    // stage D: log difference, magnitude
    logic [LOG_W-1:0]        logv;
    logic signed [LOG_W:0]   dif;
    logic [LOG_W-1:0]        mag;

    always_comb
    begin
        logv = {top_reg[ST_D-1], lfr_reg[ST_D-1]};
        dif  = $signed({1'b0, logv}) - $signed({1'b0, LOG2_FULL});
        mag  = dif[LOG_W] ? LOG_W'(-dif) : dif[LOG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        neg_reg[ST_D] <= dif[LOG_W];
        for (int i = ST_D + 1; i < ST_F; i++)
            neg_reg[i] <= neg_reg[i-1];
        n_d_reg       <= {mag, {FRAC_BITS{1'b0}}};
    end

    // stage E: quotient range check
    logic [N_HI_W-1:0] n_hi;

    always_comb
        n_hi = n_d_reg[N_W-1:DIV_BITS];

    always_ff @(posedge clk)
    begin
        ovf_reg[ST_E] <= (CFG_W'(n_hi) >= g_cl);
        for (int i = ST_E + 1; i < ST_F; i++)
            ovf_reg[i] <= ovf_reg[i-1];
        rem_reg[ST_E] <= CFG_W'(n_hi);
        nlo_reg[ST_E] <= n_d_reg[DIV_BITS-1:0];
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_div
        localparam int S = ST_DIV0 + j;
        logic [CFG_W:0] t;
        logic           ge;

        always_comb
        begin
            t  = {rem_reg[S-1], nlo_reg[S-1][DIV_BITS-1-j]};
            ge = (t >= {1'b0, g_cl});
        end

        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
                q_reg[S] <= {{(DIV_BITS-1){1'b0}}, ge};
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
                q_reg[S] <= {q_reg[S-1][DIV_BITS-2:0], ge};
        end

        if (j < DIV_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[S] <= ge ? CFG_W'(t - {1'b0, g_cl}) : t[CFG_W-1:0];
                nlo_reg[S] <= nlo_reg[S-1];
            end
        end
    end

    // stage F: exponent clamp, split into shift and fraction
    logic [DIV_BITS-1:0] qf;
    logic [U_W-1:0]      u_f;
    logic                zero_f;

    always_comb
    begin
        qf     = q_reg[ST_F-1];
        zero_f = !pos_reg[ST_F-1]
               || (neg_reg[ST_F-1] && (ovf_reg[ST_F-1] || (qf > E_MIN_MAG)));
        if (neg_reg[ST_F-1])
            u_f = U_OFF - qf;
        else if (ovf_reg[ST_F-1] || (qf > E_MAX))
            u_f = U_OFF + E_MAX;
        else
            u_f = U_OFF + qf;
    end

    always_ff @(posedge clk)
    begin
        zero_reg[ST_F] <= zero_f;
        sh_reg[ST_F]   <= SH_BASE - u_f[U_W-1:LOG_FRAC];
        for (int i = ST_F + 1; i < ST_G; i++)
        begin
            zero_reg[i] <= zero_reg[i-1];
            sh_reg[i]   <= sh_reg[i-1];
        end
        efr_reg[ST_F]  <= u_f[LOG_FRAC-1:0];
    end

    // exp2 fraction: one root product per stage
    for (genvar k = 0; k < LOG_FRAC; k++)
    begin : g_exp
        localparam int             S    = ST_EXP0 + k;
        localparam logic [M_W-1:0] ROOT = root_val(k);
        logic [M_W-1:0]   acc_in;
        logic [2*M_W-1:0] pr;

        if (k == 0)
        begin : g_first
            always_comb
                acc_in = M_W'(1) << (M_W - 1);
        end
        else
        begin : g_rest
            always_comb
                acc_in = acc_reg[S-1];
        end

        always_comb
            pr = acc_in * ROOT;

        always_ff @(posedge clk)
            acc_reg[S] <= efr_reg[S-1][LOG_FRAC-1-k] ? pr[2*M_W-2:M_W-1] : acc_in;

        if (k < LOG_FRAC - 1)
        begin : g_carry
            always_ff @(posedge clk)
                efr_reg[S] <= efr_reg[S-1];
        end
    end

    // stage G: scale and choose the path
    logic [BIG_W-1:0] big;
    logic [BIG_W-1:0] curve_nl;

    always_comb
    begin
        big      = BIG_W'(acc_reg[ST_G-1]) * BIG_W'(255);
        curve_nl = big >> sh_reg[ST_G-1];
    end

    always_ff @(posedge clk)
    begin
        if (cfg.gamma == CFG_W'(ONE_Q))
            curve_reg <= CURVE_W'(line_reg[ST_G-1]) <<< (16 - FRAC_BITS);
        else if (zero_reg[ST_G-1])
            curve_reg <= '0;
        else
            curve_reg <= $signed(CURVE_W'(curve_nl));
    end

    // stage H: brightness and saturation
    logic signed [31:0] sum;
    logic [23:0]        sum_hi;

    always_comb
    begin
        sum    = 32'(curve_reg) + (32'(b_cl) <<< BRIGHT_SH);
        sum_hi = sum[31:8];
    end

    always_ff @(posedge clk)
    begin
        if (sum < 0)
            ramp_reg <= '0;
        else if (|sum_hi[23:RAMP_W])
            ramp_reg <= '1;
        else
            ramp_reg <= sum_hi[RAMP_W-1:0];
    end

    assign out_valid  = vld_reg[N_STG-1];
    assign ramp_value = ramp_reg;

endmodule

### hdl/gamma_contrast_brightness_ramp_top.sv
// Top level of the display ramp block: config registers, in-flight credit
// count and output buffer around gcb_core. Needs gcb_pkg and the defines header.
//
//  channel | signals                                  | dir
//  in      | in_valid, in_ready, level[7:0]           | in
//  out     | out_valid, out_ready, ramp_value[15:0]   | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// One level per cycle while in_ready is high; each result passes through the
// 86-stage core (24 log2, 30 divide, 24 exp2 stages) and then the output buffer.
// Results queue in a BUF_DEPTH-entry buffer; in_ready drops only when
// BUF_DEPTH items are in flight or unread, so output stalls lose nothing.
// Reset restores gamma 1.0, contrast 1.0, brightness 0; cfg_ready is always high.
`timescale 1ns / 1ps
`include "gamma_contrast_brightness_ramp_top_defines.svh"

module gamma_contrast_brightness_ramp_top #(
    parameter int BUF_DEPTH = gcb_pkg::BUF_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gcb_pkg::LEVEL_W-1:0] level,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gcb_pkg::RAMP_W-1:0]  ramp_value,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gcb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gcb_pkg::CFG_W-1:0]   cfg_data
);
    import gcb_pkg::*;

    localparam int PTR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);

    cfg_t cfg_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  mem_cnt_reg;
    logic [CNT_W-1:0]  mem_cnt_next;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [RAMP_W-1:0] ramp_value_reg;
    logic [RAMP_W-1:0] buf_mem [BUF_DEPTH];

    logic              accept;
    logic              fetch;
    logic              core_valid;
    logic [RAMP_W-1:0] core_ramp;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gamma      <= CFG_W'(ONE_Q);
            cfg_reg.contrast   <= CFG_W'(ONE_Q);
            cfg_reg.brightness <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAMMA:    cfg_reg.gamma      <= cfg_data;
                REG_CONTRAST: cfg_reg.contrast   <= cfg_data;
                REG_BRIGHT:   cfg_reg.brightness <= $signed(cfg_data[BRIGHT_W-1:0]);
                default:      ;
            endcase
        end
    end

    assign in_ready = (cnt_reg < CNT_W'(BUF_DEPTH));
    assign accept   = in_valid && in_ready;

    gcb_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (accept),
        .level      (level),
        .out_valid  (core_valid),
        .ramp_value (core_ramp)
    );

    always_comb
    begin
        fetch          = (mem_cnt_reg != '0) && (!out_valid_reg || out_ready);
        out_valid_next = fetch || (out_valid_reg && !out_ready);
        mem_cnt_next   = mem_cnt_reg + CNT_W'(core_valid) - CNT_W'(fetch);
        cnt_next       = cnt_reg + CNT_W'(accept) - CNT_W'(out_valid_reg && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            mem_cnt_reg   <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            mem_cnt_reg   <= mem_cnt_next;
            out_valid_reg <= out_valid_next;
            if (core_valid)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (fetch)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid)
            buf_mem[wr_ptr_reg] <= core_ramp;
    end

    always_ff @(posedge clk)
    begin
        if (fetch)
            ramp_value_reg <= buf_mem[rd_ptr_reg];
    end

    assign out_valid  = out_valid_reg;
    assign ramp_value = ramp_value_reg;

    `GCB_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(BUF_DEPTH), "credit count over buffer depth")
    `GCB_ASSERT(a_buf_fits, (mem_cnt_reg + CNT_W'(out_valid_reg)) <= cnt_reg, "buffer holds more than in flight")
    `GCB_ASSERT_NEVER(a_no_overrun, core_valid && (mem_cnt_reg == CNT_W'(BUF_DEPTH)), "result written to full buffer")

endmodule
